[hdl/kesc_pkg.sv]
// types, codes and the scan code lookup shared by the key event encoder
`default_nettype none

package kesc_pkg;

    typedef enum logic [1:0] {
        CMD_KEY_EVENT = 2'd0,
        CMD_POP       = 2'd1,
        CMD_PEEK      = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] key_code;
        logic       key_down;
        logic       extended;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [1:0] queued_count;
        logic [1:0] dropped_count;
    } t_result;

    // queue control from the encoder, status back from the queue
    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
        logic       clear;
    } t_q_ctrl;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head;
    } t_q_stat;

    localparam logic [7:0] EXT_PREFIX  = 8'hE0;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] KEY_SHIFT   = 8'h10;
    localparam logic [7:0] KEY_CTRL    = 8'h11;
    localparam logic [7:0] SC_CTRL     = 8'h1D;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_LSHIFT   = 8'h2A;
    localparam logic [7:0] SC_NONE     = 8'h00;

    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
        8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
        8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
        8'h15, 8'h2C
    };

    // make code of a virtual key, SC_NONE when the key has no mapping
    function automatic logic [7:0] make_code(input logic [7:0] k, input logic ext);
        logic [7:0] code;
        logic [4:0] idx;
        code = SC_NONE;
        idx  = 5'(k - 8'h41);
        if (k inside {[8'h70:8'h79]}) begin
            code = k - 8'h70 + 8'd59;
        end else if (k inside {[8'h31:8'h39]}) begin
            code = k - 8'h31 + 8'd2;
        end else if (k == 8'h30) begin
            code = 8'd11;
        end else if (k inside {[8'h41:8'h5A]}) begin
            code = LETTER_CODES[idx];
        end else begin
            case (k)
                8'hC0:     code = 8'd41;
                8'hBB:     code = 8'd13;
                8'hBA:     code = 8'd39;
                8'hBC:     code = 8'd51;
                8'hBE:     code = 8'd52;
                8'hDE:     code = 8'd40;
                8'hBD:     code = 8'd12;
                8'hBF:     code = 8'd53;
                8'hDB:     code = 8'd26;
                8'hDC:     code = 8'd43;
                8'hDD:     code = 8'd27;
                8'h1B:     code = 8'd1;
                8'h20:     code = 8'd57;
                8'h09:     code = 8'd15;
                8'h08:     code = 8'd14;
                8'h0D:     code = 8'd28;
                8'h2E:     code = 8'h53;
                8'h14:     code = 8'h3A;
                KEY_SHIFT: code = ext ? SC_RSHIFT : SC_LSHIFT;
                KEY_CTRL:  code = SC_CTRL;
                default:   code = SC_NONE;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/key_event_to_scan_code_fifo_unit.sv]
// key event to set 1 scan code encoder feeding a byte queue
// result path: an accepted command passes the input and result registers to o_done;
//   a right ctrl key event first raises busy while it writes its prefix byte
// throughput: one command per cycle while busy is low (one queue write port)
// reset: synchronous active low, empties the queue and drops any work in flight
// results cannot be held off: o_done marks each result for exactly one cycle
`default_nettype none

module key_event_to_scan_code_fifo_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire kesc_pkg::t_item i_item,
    output logic                 o_done,
    output kesc_pkg::t_result    o_result
);

    // input register
    logic            r_valid, n_valid;
    kesc_pkg::t_item r_item;
    logic            accept;

    // set while a prefixed event writes its final byte, and whether its prefix got stored
    logic r_second, n_second;
    logic r_first_ok, n_first_ok;

    // result register
    logic              r_done, n_done;
    kesc_pkg::t_result r_result, n_result;

    kesc_pkg::t_q_ctrl q_ctrl;
    kesc_pkg::t_q_stat q_stat;

    logic [7:0] code;
    logic       mapped;
    logic       two_byte;

    kesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .o_stat  (q_stat)
    );

    assign code     = kesc_pkg::make_code(r_item.key_code, r_item.extended);
    assign mapped   = (code != kesc_pkg::SC_NONE);
    assign two_byte = (r_item.cmd == kesc_pkg::CMD_KEY_EVENT) && mapped
                      && (r_item.key_code == kesc_pkg::KEY_CTRL) && r_item.extended;

    // hold off the next transaction while the prefix byte is written
    assign busy   = r_valid && two_byte && !r_second;
    assign accept = start && !busy;

    always_comb begin
        n_valid    = accept || busy;
        n_second   = busy;
        n_first_ok = r_first_ok;
        n_done     = 1'b0;
        n_result   = '0;
        q_ctrl     = '0;
        if (r_valid) begin
            case (r_item.cmd)
                kesc_pkg::CMD_KEY_EVENT: begin
                    if (!mapped) begin
                        n_done = 1'b1;
                    end else if (two_byte && !r_second) begin
                        // prefix byte, not touched by the break bit
                        q_ctrl.push      = !q_stat.full;
                        q_ctrl.push_data = kesc_pkg::EXT_PREFIX;
                        n_first_ok       = !q_stat.full;
                    end else begin
                        q_ctrl.push      = !q_stat.full;
                        q_ctrl.push_data = r_item.key_down ? code
                                           : (code | kesc_pkg::BREAK_BIT);
                        n_done           = 1'b1;
                        n_result.queued_count  = {1'b0, two_byte && r_first_ok}
                                                 + {1'b0, !q_stat.full};
                        n_result.dropped_count = {1'b0, two_byte && !r_first_ok}
                                                 + {1'b0, q_stat.full};
                    end
                end
                kesc_pkg::CMD_POP, kesc_pkg::CMD_PEEK: begin
                    n_done = 1'b1;
                    if (!q_stat.empty) begin
                        n_result.out_byte  = q_stat.head;
                        n_result.out_valid = 1'b1;
                        q_ctrl.pop         = (r_item.cmd == kesc_pkg::CMD_POP);
                    end
                end
                kesc_pkg::CMD_CLEAR: begin
                    // stored bytes stay in the array but become unreachable
                    q_ctrl.clear = 1'b1;
                    n_done       = 1'b1;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_second   <= 1'b0;
            r_first_ok <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_second   <= n_second;
            r_first_ok <= n_first_ok;
            r_done     <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hdl/kesc_queue.sv]
// ring queue of scan code bytes with a registered head read
`default_nettype none

module kesc_queue #(
    parameter int DEPTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire kesc_pkg::t_q_ctrl i_ctrl,
    output kesc_pkg::t_q_stat      o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] full_at;
    logic [7:0]    r_head;

    always_comb begin
        full_at = (r_rp == '0) ? LAST : r_rp - PW'(1);
        n_wp    = r_wp;
        n_rp    = r_rp;
        if (i_ctrl.clear) begin
            n_wp = '0;
            n_rp = '0;
        end else begin
            if (i_ctrl.push) begin
                n_wp = (r_wp == LAST) ? '0 : r_wp + PW'(1);
            end
            if (i_ctrl.pop) begin
                n_rp = (r_rp == LAST) ? '0 : r_rp + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // head register follows the next read pointer, bypassing a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_wp] <= i_ctrl.push_data;
        end
        if (i_ctrl.push && (r_wp == n_rp)) begin
            r_head <= i_ctrl.push_data;
        end else begin
            r_head <= mem[n_rp];
        end
    end

    assign o_stat.empty = (r_wp == r_rp);
    assign o_stat.full  = (r_wp == full_at);
    assign o_stat.head  = r_head;

endmodule

`default_nettype wire

[hdl/kesc_checker.sv]
// port level checks for the key event encoder, bound to the top level
`default_nettype none

module kesc_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    start,
    input wire                    busy,
    input wire                    o_done,
    input wire kesc_pkg::t_result o_result
);

    // the prefix cycle never stretches past one cycle
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // a prefix cycle produces no result in the following cycle
    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !o_done)
        else $error("result strobe right after a prefix cycle");

    // a transaction with no prefix byte returns its result via the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) ##1 !busy |=> o_done)
        else $error("missing result for an accepted transaction");

    // a read result carries no queue counts
    a_read_no_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.out_valid |-> (o_done && o_result.queued_count == 2'd0
                                && o_result.dropped_count == 2'd0))
        else $error("read result with counts or without strobe");

    // a key event stores or drops at most two bytes
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_result.queued_count}
                    + {1'b0, o_result.dropped_count} <= 3'd2))
        else $error("more than two bytes reported for one transaction");

endmodule

bind key_event_to_scan_code_fifo_unit kesc_checker u_kesc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
